>>> rtl/core/can_sync_position_collector_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sync position collector core
// Forms for the concurrent checks in the core's execution stage.
// ----------------------------------------------------------------------------
`ifndef CAN_SYNC_POSITION_COLLECTOR_CORE_MACROS_SVH
`define CAN_SYNC_POSITION_COLLECTOR_CORE_MACROS_SVH

// Property checked on every clock edge outside reset.
`define SPC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next one.
`define SPC_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/can_spc_pkg.sv
// ----------------------------------------------------------------------------
// Sync position collector package
// Payload types, queue entry, codes and identifier constants of the core.
// ----------------------------------------------------------------------------
package can_spc_pkg;

   // Build-time defaults.
   localparam int NodeCountDefault = 8;
   localparam int QueueDepth       = 2;

   // Configuration port.
   localparam int CsrIndexWidth = 1;
   localparam int CsrDataWidth  = 8;
   localparam logic [CsrIndexWidth-1:0] CsrNodeMask    = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CsrSecondPos   = 1'b1;

   // Operation codes.
   localparam logic [1:0] OpStart   = 2'd0;
   localparam logic [1:0] OpFrame   = 2'd1;
   localparam logic [1:0] OpTimeout = 2'd2;

   // Failure reasons.
   localparam logic [1:0] FailNone      = 2'd0;
   localparam logic [1:0] FailEmergency = 2'd1;
   localparam logic [1:0] FailSilent    = 2'd2;

   // Identifier groups, limited to the 11 identifier bits.
   localparam logic [10:0] IdGroupMask = 11'h7f0;
   localparam logic [10:0] IdPosition  = 11'h380;
   localparam logic [10:0] IdEmergency = 11'h080;
   localparam logic [7:0]  ErrorLimit  = 8'd4;
   localparam logic [7:0]  ErrorMax    = 8'hff;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] tick_index;
      logic [10:0] frame_id;
      logic [31:0] data_low;
      logic [31:0] data_high;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]         node;
      logic signed [31:0] position;
      logic [31:0]        aux_a;
      logic [15:0]        aux_b;
      logic               position_valid;
      logic               cycle_done;
      logic               missed_tick;
      logic               force_fail;
      logic [1:0]         fail_reason;
      logic               paused;
      logic [7:0]         pending_nodes;
      logic [7:0]         error_count;
   } rsp_payload_type;

   // Classified request as held in the queue.
   typedef struct packed {
      logic        op_start;
      logic        op_frame;
      logic        op_timeout;
      logic        is_emergency;
      logic        is_position;
      logic        window_tick;
      logic [2:0]  node;
      logic [31:0] data_low;
      logic [31:0] data_high;
   } entry_type;

   typedef struct packed {
      logic [7:0] node_mask;
      logic       second_position_mode;
   } cfg_type;

   // True when the tick number is a multiple of twenty: a multiple of four
   // and of five. Since sixteen is one modulo five, the hex digits are summed
   // and folded once more before a small lookup.
   function automatic logic window_tick_match(input logic [15:0] tick);
      logic [5:0] digit_sum;
      logic [4:0] fold;
      logic       mult5;
      digit_sum = 6'(tick[3:0]) + 6'(tick[7:4]) + 6'(tick[11:8]) + 6'(tick[15:12]);
      fold      = 5'(digit_sum[5:4]) + 5'(digit_sum[3:0]);
      case (fold)
         5'd0, 5'd5, 5'd10, 5'd15: mult5 = 1'b1;
         default:                  mult5 = 1'b0;
      endcase
      return mult5 && (tick[1:0] == 2'b00);
   endfunction

endpackage

>>> rtl/core/can_spc_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one collector request.
// ----------------------------------------------------------------------------
interface can_spc_req_if;
   import can_spc_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/can_spc_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one collector result.
// ----------------------------------------------------------------------------
interface can_spc_rsp_if;
   import can_spc_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/can_spc_front.sv
// ----------------------------------------------------------------------------
// Collector front end
// Accepts requests, decodes the operation and identifier and pushes the
// classified request into the queue.
// ----------------------------------------------------------------------------
module can_spc_front (
   can_spc_req_if.sink            req_bus,
   input  logic                   queue_full,
   output logic                   push_valid,
   output can_spc_pkg::entry_type push_entry
);
   import can_spc_pkg::*;

   logic [10:0] id_group;

   // A request is taken whenever the queue has room.
   assign req_bus.ready = !queue_full;
   assign push_valid    = req_bus.valid && !queue_full;

   // Classification of the operation and identifier group.
   assign id_group = req_bus.payload.frame_id & IdGroupMask;

   always_comb begin
      push_entry              = '0;
      push_entry.op_start     = (req_bus.payload.operation == OpStart);
      push_entry.op_frame     = (req_bus.payload.operation == OpFrame);
      push_entry.op_timeout   = (req_bus.payload.operation == OpTimeout);
      push_entry.is_emergency = (id_group == IdEmergency);
      push_entry.is_position  = (id_group == IdPosition);
      push_entry.window_tick  = window_tick_match(req_bus.payload.tick_index);
      push_entry.node         = req_bus.payload.frame_id[2:0];
      push_entry.data_low     = req_bus.payload.data_low;
      push_entry.data_high    = req_bus.payload.data_high;
   end
endmodule

>>> rtl/core/can_spc_queue.sv
// ----------------------------------------------------------------------------
// Collector request queue
// Short register FIFO between the front end and the execution stage.
// ----------------------------------------------------------------------------
module can_spc_queue #(
   parameter int DEPTH = can_spc_pkg::QueueDepth
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  can_spc_pkg::entry_type push_entry,
   output logic                   full,
   input  logic                   pop_ready,
   output logic                   pop_valid,
   output can_spc_pkg::entry_type pop_entry
);
   import can_spc_pkg::*;

   localparam int PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0]   LastPtr   = PtrWidth'(DEPTH - 1);
   localparam logic [CountWidth-1:0] DepthCnt  = CountWidth'(DEPTH);

   entry_type               store_ff [DEPTH];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]   count_ff, count_in;
   logic                    do_push, do_pop;

   assign full      = (count_ff == DepthCnt);
   assign pop_valid = (count_ff != '0);
   assign pop_entry = store_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end
endmodule

>>> rtl/core/can_spc_back.sv
// ----------------------------------------------------------------------------
// Collector execution stage
// Applies queued requests to the pending mask, error window and paused
// flag, and holds the result in the response register.
// ----------------------------------------------------------------------------
`include "can_sync_position_collector_core_macros.svh"

module can_spc_back #(
   parameter int NODE_COUNT = can_spc_pkg::NodeCountDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  can_spc_pkg::cfg_type   cfg,
   input  logic                   entry_valid,
   input  can_spc_pkg::entry_type entry,
   output logic                   entry_ready,
   can_spc_rsp_if.source          rsp_bus
);
   import can_spc_pkg::*;

   localparam logic [7:0] ActiveMask = 8'((9'd1 << NODE_COUNT) - 9'd1);

   logic [7:0]      pending_ff, pending_in;
   logic [7:0]      errors_ff, errors_in;
   logic            paused_ff, paused_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, result_in;
   logic            load;
   logic [7:0]      errors_inc;

   // A new result is loaded when the response register is empty or drained.
   assign load        = entry_valid && (!rsp_valid_ff || rsp_bus.ready);
   assign entry_ready = !rsp_valid_ff || rsp_bus.ready;
   assign errors_inc  = (errors_ff != ErrorMax) ? errors_ff + 8'd1 : errors_ff;

   // State update and result for the request at the head of the queue.
   always_comb begin
      pending_in = pending_ff;
      errors_in  = errors_ff;
      paused_in  = paused_ff;
      result_in  = '0;
      if (entry.op_start) begin
         pending_in = cfg.node_mask & ActiveMask;
         if (entry.window_tick && !paused_ff) begin
            errors_in = 8'd0;
         end
         result_in.cycle_done = (pending_in == 8'd0);
      end else if (entry.op_frame) begin
         if (!paused_ff && entry.is_emergency) begin
            result_in.force_fail  = 1'b1;
            result_in.fail_reason = FailEmergency;
            paused_in             = 1'b1;
         end
         if ((pending_ff != 8'd0) && entry.is_position) begin
            result_in.node           = entry.node;
            result_in.position       = entry.data_low;
            result_in.position_valid = 1'b1;
            if (cfg.second_position_mode) begin
               result_in.aux_a = entry.data_high;
            end else begin
               result_in.aux_a = {16'd0, entry.data_high[15:0]};
               result_in.aux_b = entry.data_high[31:16];
            end
            pending_in           = pending_ff & ~(8'd1 << entry.node);
            result_in.cycle_done = (pending_in == 8'd0);
         end
      end else if (entry.op_timeout) begin
         if (pending_ff != 8'd0) begin
            result_in.missed_tick = 1'b1;
            result_in.cycle_done  = 1'b1;
            errors_in             = errors_inc;
            if (errors_inc > ErrorLimit) begin
               if (!paused_ff) begin
                  result_in.force_fail  = 1'b1;
                  result_in.fail_reason = FailSilent;
               end
               paused_in = 1'b1;
            end
            pending_in = 8'd0;
         end
      end
      result_in.paused        = paused_in;
      result_in.pending_nodes = pending_in;
      result_in.error_count   = errors_in;
   end

   // Response valid flag: set on load, cleared once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         errors_ff    <= '0;
         paused_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            pending_ff <= pending_in;
            errors_ff  <= errors_in;
            paused_ff  <= paused_in;
         end
      end
   end

   // Response payload register needs no reset.
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= result_in;
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_ff;

   // Checks on the collector state.
   `SPC_ASSERT(a_fail_once, clock, reset, !(load && result_in.force_fail && paused_ff), "force-fail issued while already paused")
   `SPC_ASSERT_NEXT(a_fail_pauses, clock, reset, load && result_in.force_fail, paused_ff, "force-fail did not latch paused")
   `SPC_ASSERT_NEXT(a_timeout_clears, clock, reset, load && result_in.missed_tick, pending_ff == 8'd0, "timeout left nodes pending")
   `SPC_ASSERT_NEXT(a_result_matches, clock, reset, load, rsp_bus.valid && (rsp_bus.payload.pending_nodes == pending_ff), "result and pending mask disagree")
endmodule

>>> rtl/core/can_sync_position_collector_core.sv
// ----------------------------------------------------------------------------
// Sync position collector core
// Collects motor node position replies after each CAN sync.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one request per handshake: start cycle, received frame
//   or reply timeout. rsp_bus returns exactly one result per request, in
//   order. csr_we with csr_index and csr_data writes the node mask or the
//   second-position mode; write them only while no request is in flight.
//   An accepted request is written into the queue; the execution stage
//   loads its result from the queue head into the response register.
//   Throughput: one request per cycle while results are taken; the
//   execution stage updates its state combinationally, and the two-entry
//   queue keeps the front end accepting while a result waits to be taken.
//   When the receiver stalls, the result holds in the response register
//   and the queue fills; req_bus.ready drops once the queue is full.
//   Reset clears the pending mask, error window, paused flag, queue and
//   configuration registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
module can_sync_position_collector_core #(
   parameter int NODE_COUNT = can_spc_pkg::NodeCountDefault
) (
   input  logic                                    clock,
   input  logic                                    reset,
   can_spc_req_if.sink                             req_bus,
   can_spc_rsp_if.source                           rsp_bus,
   input  logic                                    csr_we,
   input  logic [can_spc_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [can_spc_pkg::CsrDataWidth-1:0]    csr_data
);
   import can_spc_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      queue_full;
   logic      push_valid;
   entry_type push_entry;
   logic      pop_valid;
   logic      pop_ready;
   entry_type pop_entry;

   // Configuration registers.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CsrNodeMask:  cfg_in.node_mask            = csr_data;
            CsrSecondPos: cfg_in.second_position_mode = csr_data[0];
            default:      cfg_in                      = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end, queue and execution stage.
   can_spc_front u_front (
      .req_bus    (req_bus),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   can_spc_queue #(
      .DEPTH (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop_ready  (pop_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   can_spc_back #(
      .NODE_COUNT (NODE_COUNT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .entry_valid (pop_valid),
      .entry       (pop_entry),
      .entry_ready (pop_ready),
      .rsp_bus     (rsp_bus)
   );
endmodule

>>> dv/tb_can_sync_position_collector_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sync position collector core testbench
// Drives start, frame, timeout and unused requests through the valid/ready
// channels and checks every result, field by field, against a fixed value
// or a predictor of the pending mask, error window and paused flag. A
// directed table comes first, then random collection cycles under several
// register settings, a long receiver hold-off, repeated misses that pause.
// ----------------------------------------------------------------------------
module tb_can_sync_position_collector_core;
   import can_spc_pkg::*;

   localparam int          ResetCycles = 11;
   localparam int          DrainCycles = 8;
   localparam int          CycleLimit  = 100000;
   localparam int          HoldCycles  = 60;
   localparam int          PhaseItems  = 55;
   localparam int          PauseItems  = 50;
   localparam int          MissRounds  = 12;
   localparam int          WindowTicks = 20;
   localparam logic [1:0]  OpUnused    = 2'd3;
   localparam logic [7:0]  NodeLimit   = 8'((16'd1 << NodeCountDefault) - 16'd1);

   // Results that can be read straight off the behaviour.
   localparam rsp_payload_type RspQuiet      = '0;
   localparam rsp_payload_type RspEmptyStart = '{cycle_done: 1'b1, default: '0};
   localparam rsp_payload_type RspAllPending = '{pending_nodes: 8'hff, default: '0};
   localparam rsp_payload_type RspNodeSeven  = '{node: 3'd7, position: 32'sh8000_0000,
                                                 aux_a: 32'hffff_ffff, position_valid: 1'b1,
                                                 pending_nodes: 8'h7f, default: '0};
   localparam rsp_payload_type RspFirstMiss  = '{cycle_done: 1'b1, missed_tick: 1'b1,
                                                 error_count: 8'd1, default: '0};

   typedef enum logic [1:0] {RowRequest, RowNodeMask, RowSecondPos} row_kind_type;

   typedef struct {
      row_kind_type    kind;
      logic [7:0]      value;
      req_payload_type req;
      bit              fixed;
      rsp_payload_type rsp;
   } stim_row_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_we;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_data;

   can_spc_req_if req_if ();
   can_spc_rsp_if rsp_if ();

   // Predictor state and register copies.
   logic [7:0]      pending_q;
   logic [7:0]      window_err_q;
   logic            paused_q;
   logic [7:0]      cfg_mask;
   logic            cfg_second;

   rsp_payload_type expected_rsp [$];
   stim_row_type    directed_rows [$];
   int unsigned     sent_count;
   int unsigned     mismatches;
   int unsigned     cycle_count;
   bit              idle_off;
   bit              long_hold_due;

   can_sync_position_collector_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_if),
      .rsp_bus   (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // Works out the result of one request and moves the collector state on.
   function automatic rsp_payload_type collect_step(input req_payload_type item);
      rsp_payload_type outcome;
      logic            is_position;
      logic            is_emergency;
      outcome      = '0;
      is_position  = (item.frame_id & IdGroupMask) == IdPosition;
      is_emergency = (item.frame_id & IdGroupMask) == IdEmergency;
      case (item.operation)
         OpStart: begin
            pending_q = cfg_mask & NodeLimit;
            if (item.tick_index % 16'(WindowTicks) == 16'd0 && !paused_q)
               window_err_q = '0;
            outcome.cycle_done = (pending_q == '0);
         end
         OpFrame: begin
            if (!paused_q && is_emergency) begin
               outcome.force_fail  = 1'b1;
               outcome.fail_reason = FailEmergency;
               paused_q            = 1'b1;
            end
            if (pending_q != '0 && is_position) begin
               outcome.node     = item.frame_id[2:0];
               outcome.position = item.data_low;
               if (cfg_second) begin
                  outcome.aux_a = item.data_high;
               end else begin
                  outcome.aux_a = {16'h0, item.data_high[15:0]};
                  outcome.aux_b = item.data_high[31:16];
               end
               outcome.position_valid     = 1'b1;
               pending_q[outcome.node]    = 1'b0;
               outcome.cycle_done         = (pending_q == '0);
            end
         end
         OpTimeout: begin
            if (pending_q != '0) begin
               outcome.missed_tick = 1'b1;
               outcome.cycle_done  = 1'b1;
               if (window_err_q != ErrorMax)
                  window_err_q = window_err_q + 8'd1;
               if (window_err_q > ErrorLimit) begin
                  if (!paused_q) begin
                     outcome.force_fail  = 1'b1;
                     outcome.fail_reason = FailSilent;
                  end
                  paused_q = 1'b1;
               end
               pending_q = '0;
            end
         end
         default: ;
      endcase
      outcome.paused        = paused_q;
      outcome.pending_nodes = pending_q;
      outcome.error_count   = window_err_q;
      return outcome;
   endfunction

   function automatic req_payload_type make_request(input logic [1:0] op,
                                                    input logic [15:0] tick,
                                                    input logic [10:0] id,
                                                    input logic [31:0] low,
                                                    input logic [31:0] high);
      req_payload_type item;
      item.operation  = op;
      item.tick_index = tick;
      item.frame_id   = id;
      item.data_low   = low;
      item.data_high  = high;
      return item;
   endfunction

   // Data word with a fair share of sign and width extremes.
   function automatic logic [31:0] data_word();
      case ($urandom_range(15))
         0:       return 32'h0000_0000;
         1:       return 32'hffff_ffff;
         2:       return 32'h8000_0000;
         3:       return 32'h7fff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // Tick number for a start; a window tick is forced while the error
   // count is close to the limit and pausing is not wanted yet.
   function automatic logic [15:0] window_tick_value(input bit allow_pause);
      if ($urandom_range(3) == 0 || (!allow_pause && window_err_q >= ErrorLimit - 8'd1))
         return 16'(WindowTicks * $urandom_range(0, 3276));
      return 16'($urandom);
   endfunction

   // Any kind of request with random content, unused code included.
   function automatic req_payload_type noise_request(input bit allow_pause);
      req_payload_type item;
      int unsigned     pick;
      item = make_request(OpUnused, window_tick_value(allow_pause), 11'($urandom),
                          data_word(), data_word());
      pick = $urandom_range(99);
      if (pick < 20) begin
         item.operation = OpStart;
      end else if (pick < 75) begin
         item.operation = OpFrame;
         pick = $urandom_range(99);
         if (pick < 40)
            item.frame_id = {IdPosition[10:4], 4'($urandom)};
         else if (allow_pause && pick < 65)
            item.frame_id = {IdEmergency[10:4], 4'($urandom)};
         if (!allow_pause && (item.frame_id & IdGroupMask) == IdEmergency)
            item.frame_id[8] = ~item.frame_id[8];
      end else if (pick < 90 && (allow_pause || window_err_q < ErrorLimit)) begin
         item.operation = OpTimeout;
      end
      return item;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // Offers one request, holding it until taken, then records its result.
   task automatic send_request(input req_payload_type item, input bit use_fixed,
                               input rsp_payload_type fixed_rsp);
      rsp_payload_type predicted;
      while (!idle_off && $urandom_range(99) < 6) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      predicted = collect_step(item);
      expected_rsp.push_back(use_fixed ? fixed_rsp : predicted);
      sent_count++;
   endtask

   task automatic send_item(input req_payload_type item);
      send_request(item, 1'b0, RspQuiet);
   endtask

   // Stops offering and waits until every result has been taken.
   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (expected_rsp.size() != 0)
         @(posedge clock);
   endtask

   // One register write; the strobe then rests low before the task returns, so
   // that writes issued back to back each get an edge of their own.
   task automatic write_csr(input logic [CsrIndexWidth-1:0] index,
                            input logic [CsrDataWidth-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == CsrNodeMask)
         cfg_mask = value;
      else
         cfg_second = value[0];
      @(posedge clock);
   endtask

   // One collection cycle: a start, the replies of the pending nodes in a
   // shuffled order with some dropped and some noise between, then perhaps
   // a timeout for whatever is still outstanding.
   task automatic run_cycle(input bit allow_pause);
      logic [2:0] order [8];
      logic [2:0] swap;
      int         count;
      int         pos;
      send_item(make_request(OpStart, window_tick_value(allow_pause), 11'($urandom),
                             data_word(), data_word()));
      count = 0;
      for (int n = 0; n < 8; n++) begin
         if (pending_q[n]) begin
            order[count] = 3'(n);
            count++;
         end
      end
      for (int j = count - 1; j > 0; j--) begin
         pos        = $urandom_range(j);
         swap       = order[j];
         order[j]   = order[pos];
         order[pos] = swap;
      end
      for (int j = 0; j < count; j++) begin
         if ($urandom_range(99) < 15)
            send_item(noise_request(allow_pause));
         if ($urandom_range(99) < 88)
            send_item(make_request(OpFrame, 16'($urandom),
                                   {IdPosition[10:4], 1'($urandom), order[j]},
                                   data_word(), data_word()));
      end
      if (pending_q != '0 && (allow_pause || window_err_q < ErrorLimit) &&
          $urandom_range(99) < 70)
         send_item(make_request(OpTimeout, 16'($urandom), 11'($urandom),
                                data_word(), data_word()));
   endtask

   // Result receiver: random stalls, and one long hold-off when asked.
   initial begin : result_sink
      int unsigned hold_left;
      hold_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            hold_left     = HoldCycles;
         end
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (hold_left != 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready <= idle_off || ($urandom_range(99) >= 6);
         end
      end
   end

   // Each result taken is compared with the oldest expectation.
   always @(posedge clock) begin : result_check
      rsp_payload_type want;
      rsp_payload_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         if (expected_rsp.size() == 0) begin
            $error("result taken with no request outstanding");
            mismatches++;
         end else begin
            want = expected_rsp.pop_front();
            check_field("node", 32'(want.node), 32'(got.node));
            check_field("position", want.position, got.position);
            check_field("aux_a", want.aux_a, got.aux_a);
            check_field("aux_b", 32'(want.aux_b), 32'(got.aux_b));
            check_field("position_valid", 32'(want.position_valid), 32'(got.position_valid));
            check_field("cycle_done", 32'(want.cycle_done), 32'(got.cycle_done));
            check_field("missed_tick", 32'(want.missed_tick), 32'(got.missed_tick));
            check_field("force_fail", 32'(want.force_fail), 32'(got.force_fail));
            check_field("fail_reason", 32'(want.fail_reason), 32'(got.fail_reason));
            check_field("paused", 32'(want.paused), 32'(got.paused));
            check_field("pending_nodes", 32'(want.pending_nodes), 32'(got.pending_nodes));
            check_field("error_count", 32'(want.error_count), 32'(got.error_count));
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : stimulus
      logic [7:0]  phase_mask;
      int unsigned phase_end;
      pending_q      = '0;
      window_err_q   = '0;
      paused_q       = 1'b0;
      cfg_mask       = '0;
      cfg_second     = 1'b0;
      sent_count     = 0;
      mismatches     = 0;
      idle_off       = 1'b0;
      long_hold_due  = 1'b0;
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      csr_we         <= 1'b0;
      csr_index      <= '0;
      csr_data       <= '0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // Empty mask: unused code, empty start, stray reply and stray timeout.
      directed_rows.push_back('{RowNodeMask, 8'h00, '0, 1'b0, RspQuiet});
      directed_rows.push_back('{RowSecondPos, 8'h00, '0, 1'b0, RspQuiet});
      directed_rows.push_back('{RowRequest, 8'h00, make_request(OpUnused, 16'hffff, 11'h7ff,
                                32'hffff_ffff, 32'hffff_ffff), 1'b1, RspQuiet});
      directed_rows.push_back('{RowRequest, 8'h00, make_request(OpStart, 16'h0000, 11'h000,
                                32'h0, 32'h0), 1'b1, RspEmptyStart});
      directed_rows.push_back('{RowRequest, 8'h00, make_request(OpFrame, 16'h0000, 11'h385,
                                32'hffff_ffff, 32'hffff_ffff), 1'b1, RspQuiet});
      directed_rows.push_back('{RowRequest, 8'h00, make_request(OpTimeout, 16'h0000, 11'h000,
                                32'h0, 32'h0), 1'b1, RspQuiet});
      // Full mask, second position: replies, repeats, other groups, a miss.
      directed_rows.push_back('{RowNodeMask, 8'hff, '0, 1'b0, RspQuiet});
      directed_rows.push_back('{RowSecondPos, 8'h01, '0, 1'b0, RspQuiet});
      directed_rows.push_back('{RowRequest, 8'h00, make_request(OpStart, 16'hffff, 11'h000,
                                32'h0, 32'h0), 1'b1, RspAllPending});
      directed_rows.push_back('{RowRequest, 8'h00, make_request(OpFrame, 16'h0000, 11'h387,
                                32'h8000_0000, 32'hffff_ffff), 1'b1, RspNodeSeven});
      directed_rows.push_back('{RowRequest, 8'h00, make_request(OpFrame, 16'h0000, 11'h387,
                                32'h7fff_ffff, 32'h0), 1'b0, RspQuiet});
      directed_rows.push_back('{RowRequest, 8'h00, make_request(OpFrame, 16'h0000, 11'h380,
                                32'h0, 32'h0), 1'b0, RspQuiet});
      directed_rows.push_back('{RowRequest, 8'h00, make_request(OpFrame, 16'h0000, 11'h7ff,
                                32'h1234_5678, 32'h9abc_def0), 1'b0, RspQuiet});
      directed_rows.push_back('{RowRequest, 8'h00, make_request(OpFrame, 16'h0000, 11'h38f,
                                32'h1234_5678, 32'h9abc_def0), 1'b0, RspQuiet});
      directed_rows.push_back('{RowRequest, 8'h00, make_request(OpFrame, 16'h0000, 11'h000,
                                32'h1234_5678, 32'h9abc_def0), 1'b0, RspQuiet});
      directed_rows.push_back('{RowRequest, 8'h00, make_request(OpTimeout, 16'h0000, 11'h000,
                                32'h0, 32'h0), 1'b1, RspFirstMiss});
      // Two nodes, analog words: window clear, reload while pending, misses.
      directed_rows.push_back('{RowNodeMask, 8'h42, '0, 1'b0, RspQuiet});
      directed_rows.push_back('{RowSecondPos, 8'h00, '0, 1'b0, RspQuiet});
      directed_rows.push_back('{RowRequest, 8'h00, make_request(OpStart, 16'd20, 11'h000,
                                32'h0, 32'h0), 1'b0, RspQuiet});
      directed_rows.push_back('{RowRequest, 8'h00, make_request(OpFrame, 16'h0000, 11'h386,
                                32'h1, 32'habcd_1234), 1'b0, RspQuiet});
      directed_rows.push_back('{RowRequest, 8'h00, make_request(OpStart, 16'd21, 11'h000,
                                32'h0, 32'h0), 1'b0, RspQuiet});
      directed_rows.push_back('{RowRequest, 8'h00, make_request(OpFrame, 16'h0000, 11'h381,
                                32'hffff_0000, 32'h0000_ffff), 1'b0, RspQuiet});
      directed_rows.push_back('{RowRequest, 8'h00, make_request(OpFrame, 16'h0000, 11'h386,
                                32'h0000_ffff, 32'hffff_0000), 1'b0, RspQuiet});
      for (int k = 0; k < 3; k++) begin
         directed_rows.push_back('{RowRequest, 8'h00, make_request(OpStart, 16'(2 * k + 1),
                                   11'h000, 32'h0, 32'h0), 1'b0, RspQuiet});
         directed_rows.push_back('{RowRequest, 8'h00, make_request(OpTimeout, 16'h0000,
                                   11'h000, 32'h0, 32'h0), 1'b0, RspQuiet});
      end
      directed_rows.push_back('{RowRequest, 8'h00, make_request(OpStart, 16'd40, 11'h000,
                                32'h0, 32'h0), 1'b0, RspQuiet});
      directed_rows.push_back('{RowRequest, 8'h00, make_request(OpTimeout, 16'h0000, 11'h000,
                                32'h0, 32'h0), 1'b0, RspQuiet});

      foreach (directed_rows[i]) begin
         case (directed_rows[i].kind)
            RowNodeMask: begin
               drain_results();
               write_csr(CsrNodeMask, directed_rows[i].value);
            end
            RowSecondPos: begin
               drain_results();
               write_csr(CsrSecondPos, directed_rows[i].value);
            end
            default: begin
               send_request(directed_rows[i].req, directed_rows[i].fixed,
                            directed_rows[i].rsp);
            end
         endcase
      end

      // Random collection cycles, kept clear of pausing. The second phase
      // runs with no idling; the third starts with a long receiver hold-off.
      for (int p = 0; p < 6; p++) begin
         drain_results();
         case (p)
            0:       phase_mask = 8'ha5;
            1:       phase_mask = 8'h01;
            2:       phase_mask = 8'hff;
            3:       phase_mask = 8'h80;
            default: phase_mask = 8'($urandom);
         endcase
         write_csr(CsrNodeMask, phase_mask);
         write_csr(CsrSecondPos, {7'($urandom), (p < 4) ? 1'(p % 2) : 1'($urandom)});
         idle_off = (p == 1);
         if (p == 2)
            long_hold_due = 1'b1;
         phase_end = sent_count + PhaseItems;
         while (sent_count < phase_end)
            run_cycle(1'b0);
      end

      // Emergencies and over-limit misses allowed from here on.
      drain_results();
      idle_off = 1'b0;
      write_csr(CsrNodeMask, 8'($urandom_range(1, 255)));
      write_csr(CsrSecondPos, 8'($urandom));
      phase_end = sent_count + PauseItems;
      while (sent_count < phase_end)
         run_cycle(1'b1);

      // Miss after miss on ticks outside the window, so the count passes
      // the limit, the block pauses and further misses find it paused.
      drain_results();
      write_csr(CsrNodeMask, 8'hff);
      write_csr(CsrSecondPos, 8'h01);
      for (int k = 0; k < MissRounds; k++) begin
         send_item(make_request(OpStart, 16'(2 * k + 1), 11'($urandom),
                                data_word(), data_word()));
         send_item(make_request(OpTimeout, 16'($urandom), 11'($urandom),
                                data_word(), data_word()));
      end
      phase_end = sent_count + 30;
      while (sent_count < phase_end)
         run_cycle(1'b1);

      drain_results();
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
